// ===== src/tgad_pkg.sv =====
// shared types and constants for the tga run-length pixel decoder
package tgad_pkg;

  localparam int unsigned OffsetW = 24;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned RepW    = 8;
  localparam int unsigned CountW  = 10;
  localparam int unsigned DepthW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegBytesPerPixel = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageBytes    = 2'd1;

  localparam logic [DepthW-1:0] BppReset   = 3'd3;
  localparam logic [OffsetW-1:0] ImgReset  = 24'd1;

  typedef struct packed {
    logic [OffsetW-1:0] write_offset;
    logic [PixelW-1:0]  pixel_value;
    logic [RepW-1:0]    repeat_count;
    logic [CountW-1:0]  byte_count;
    logic               image_done;
    logic               truncated;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } res_req_t;

  function automatic logic [DepthW-1:0] depth_clamp(input logic [DepthW-1:0] raw);
    logic [DepthW-1:0] d;
    d = raw;
    if (raw == 3'd0) d = 3'd1;
    else if (raw > 3'd4) d = 3'd4;
    return d;
  endfunction

endpackage

// ===== src/tgad_decode.sv =====
// packet state and per-byte decode of the compressed stream
module tgad_decode import tgad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         stream_byte_i,
  input  logic               stream_end_i,
  input  logic [DepthW-1:0]  bytes_per_pixel_i,
  input  logic [OffsetW-1:0] image_bytes_i,
  output res_req_t           req_o
);

  typedef enum logic [1:0] {
    PhHeader,
    PhRepeat,
    PhLiteral
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [RepW-1:0]    pixels_left_q, pixels_left_d;
  logic [1:0]         byte_in_pixel_q, byte_in_pixel_d;
  logic [PixelW-1:0]  gather_q, gather_d;
  logic [OffsetW-1:0] bytes_done_q, bytes_done_d;
  logic               finished_q, finished_d;

  always_comb begin
    logic [DepthW-1:0]  bpp;
    logic [PixelW-1:0]  merged;
    logic [OffsetW-1:0] room;
    logic [CountW-1:0]  want;
    logic [CountW-1:0]  cnt;
    logic               complete;
    logic               wrote;
    logic               done;
    logic               is_rep;

    bpp      = depth_clamp(bytes_per_pixel_i);
    merged   = gather_q | ({24'd0, stream_byte_i} << {byte_in_pixel_q, 3'b000});
    room     = image_bytes_i - bytes_done_q;
    complete = ({1'b0, byte_in_pixel_q} + 3'd1) >= bpp;
    is_rep   = (phase_q == PhRepeat);
    want     = is_rep ? (CountW'(pixels_left_q) * CountW'(bpp)) : CountW'(bpp);
    cnt      = ({14'd0, want} < room) ? want : room[CountW-1:0];
    wrote    = 1'b0;
    done     = 1'b0;

    phase_d         = phase_q;
    pixels_left_d   = pixels_left_q;
    byte_in_pixel_d = byte_in_pixel_q;
    gather_d        = gather_q;
    bytes_done_d    = bytes_done_q;
    finished_d      = finished_q;

    req_o.push             = 1'b0;
    req_o.res.write_offset = bytes_done_q;
    req_o.res.pixel_value  = '0;
    req_o.res.repeat_count = 8'd1;
    req_o.res.byte_count   = '0;
    req_o.res.image_done   = 1'b0;
    req_o.res.truncated    = 1'b0;

    if (fire_i && !finished_q && (bytes_done_q < image_bytes_i)) begin
      case (phase_q)
        PhHeader: begin
          pixels_left_d   = {1'b0, stream_byte_i[6:0]} + 8'd1;
          phase_d         = stream_byte_i[7] ? PhRepeat : PhLiteral;
          byte_in_pixel_d = 2'd0;
          gather_d        = '0;
        end
        PhRepeat, PhLiteral: begin
          if (complete) begin
            wrote = 1'b1;
            req_o.res.pixel_value  = merged;
            req_o.res.repeat_count = is_rep ? pixels_left_q : 8'd1;
            req_o.res.byte_count   = cnt;
            bytes_done_d = bytes_done_q + {14'd0, cnt};
            if (is_rep) pixels_left_d = '0;
            else if (pixels_left_q != '0) pixels_left_d = pixels_left_q - 8'd1;
            byte_in_pixel_d = 2'd0;
            gather_d        = '0;
            if (pixels_left_d == '0) phase_d = PhHeader;
          end else begin
            byte_in_pixel_d = byte_in_pixel_q + 2'd1;
            gather_d        = merged;
          end
        end
        default: phase_d = PhHeader;
      endcase

      done = bytes_done_d >= image_bytes_i;
      if (wrote) begin
        req_o.push           = 1'b1;
        req_o.res.image_done = done;
        req_o.res.truncated  = stream_end_i && !done;
        if (done || stream_end_i) finished_d = 1'b1;
      end else if (stream_end_i) begin
        req_o.push          = 1'b1;
        req_o.res.truncated = 1'b1;
        finished_d          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhHeader;
      pixels_left_q   <= '0;
      byte_in_pixel_q <= '0;
      gather_q        <= '0;
      bytes_done_q    <= '0;
      finished_q      <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      pixels_left_q   <= pixels_left_d;
      byte_in_pixel_q <= byte_in_pixel_d;
      gather_q        <= gather_d;
      bytes_done_q    <= bytes_done_d;
      finished_q      <= finished_d;
    end
  end

`ifndef ASSERT_OFF
  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> !req_o.push) else $error("result after end of image");
  a_done_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_o.push && (req_o.res.image_done || req_o.res.truncated)) |=> finished_q)
    else $error("end of image not recorded");
  a_repeat_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_o.push && !req_o.res.truncated && req_o.res.repeat_count != 8'd1) |=>
    (phase_q == PhHeader)) else $error("repeat packet left open");
  a_done_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.push |-> !(req_o.res.image_done && req_o.res.truncated))
    else $error("done and truncated together");
`endif

endmodule

// ===== src/tgad_outbuf.sv =====
// output register holding one result until it is taken
module tgad_outbuf import tgad_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  res_req_t req_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output result_t  res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign valid_d     = req_i.push || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) res_q <= req_i.res;
  end

`ifndef ASSERT_OFF
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |-> in_ready_o) else $error("result pushed into full register");
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |=> valid_q) else $error("pushed result not shown");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (valid_q && !out_ready_i)) else $error("stall without pending result");
`endif

endmodule

// ===== src/tga_rle_pixel_decoder.sv =====
// top level of the tga run-length pixel decoder
// Takes one compressed stream byte per cycle and gives at most one write request per byte,
// held in a single output register from the cycle after the byte is accepted. in_ready_o is high
// whenever that register is empty or is being emptied in the same cycle, so with out_ready_i
// held high a byte is taken every cycle; the output register alone sets the rate under stall.
// Configuration writes are always taken (cfg_ready_o is tied high) and act at once; writes to
// an unknown index are ignored. After image completion or truncation bytes are dropped until
// reset.
module tga_rle_pixel_decoder import tgad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [OffsetW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         stream_byte_i,
  input  logic               stream_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OffsetW-1:0] write_offset_o,
  output logic [PixelW-1:0]  pixel_value_o,
  output logic [RepW-1:0]    repeat_count_o,
  output logic [CountW-1:0]  byte_count_o,
  output logic               image_done_o,
  output logic               truncated_o
);

  logic [DepthW-1:0]  bpp_q;
  logic [OffsetW-1:0] img_q;
  logic               fire;
  res_req_t           req;
  result_t            res;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= BppReset;
      img_q <= ImgReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegBytesPerPixel: bpp_q <= cfg_data_i[DepthW-1:0];
        RegImageBytes:    img_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  tgad_decode u_decode (
    .clk_i,
    .rst_ni,
    .fire_i            (fire),
    .stream_byte_i,
    .stream_end_i,
    .bytes_per_pixel_i (bpp_q),
    .image_bytes_i     (img_q),
    .req_o             (req)
  );

  tgad_outbuf u_outbuf (
    .clk_i,
    .rst_ni,
    .req_i       (req),
    .out_ready_i,
    .in_ready_o,
    .out_valid_o,
    .res_o       (res)
  );

  assign write_offset_o = res.write_offset;
  assign pixel_value_o  = res.pixel_value;
  assign repeat_count_o = res.repeat_count;
  assign byte_count_o   = res.byte_count;
  assign image_done_o   = res.image_done;
  assign truncated_o    = res.truncated;

endmodule

// ===== dv/tb_tga_rle_pixel_decoder.sv =====
// testbench for the tga run-length pixel decoder: packet streams checked against predicted writes
module tb_tga_rle_pixel_decoder import tgad_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;
  localparam logic [OffsetW-1:0] ImgMax    = 24'hFFFFFF;

  typedef enum logic [1:0] {WantHeader, InRepeat, InLiteral} pkt_phase_e;

  class rle_write_tracker;
    logic [DepthW-1:0]  bpp;
    logic [OffsetW-1:0] img_bytes;
    pkt_phase_e         phase;
    logic [7:0]         left;
    logic [1:0]         pix_pos;
    logic [PixelW-1:0]  gather;
    logic [OffsetW-1:0] done_bytes;
    bit                 finished;
    result_t            pending_writes[$];
    int                 faults;

    function new();
      bpp        = BppReset;
      img_bytes  = ImgReset;
      phase      = WantHeader;
      left       = '0;
      pix_pos    = '0;
      gather     = '0;
      done_bytes = '0;
      finished   = 1'b0;
      faults     = 0;
    endfunction

    function int depth();
      if (bpp == 3'd0) return 1;
      if (bpp > 3'd4) return 4;
      return int'(bpp);
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [OffsetW-1:0] data);
      if (idx == RegBytesPerPixel) bpp = data[DepthW-1:0];
      else if (idx == RegImageBytes) img_bytes = data;
    endfunction

    function void take_byte(input logic [7:0] b, input logic last);
      result_t w;
      int d, pos, room, want, cnt;
      bit wrote, complete;
      if (finished || done_bytes >= img_bytes) return;
      d = depth();
      wrote = 1'b0;
      w = '0;
      w.repeat_count = 8'd1;
      if (phase == WantHeader) begin
        left = 8'(b[6:0]) + 8'd1;
        phase = b[7] ? InRepeat : InLiteral;
        pix_pos = '0;
        gather = '0;
      end else begin
        pos = int'(pix_pos);
        gather |= 32'(b) << (8 * pos);
        if (pos + 1 >= d) begin
          room = int'(img_bytes) - int'(done_bytes);
          w.write_offset = done_bytes;
          w.pixel_value = gather;
          if (phase == InRepeat) begin
            w.repeat_count = left;
            want = int'(left) * d;
            left = '0;
          end else begin
            want = d;
            if (left > 0) left--;
          end
          cnt = (want < room) ? want : room;
          w.byte_count = 10'(cnt);
          done_bytes = done_bytes + 24'(cnt);
          wrote = 1'b1;
          pix_pos = '0;
          gather = '0;
          if (left == 0) phase = WantHeader;
        end else begin
          pix_pos = 2'(pos + 1);
        end
      end
      complete = done_bytes >= img_bytes;
      if (wrote) begin
        w.image_done = complete;
        w.truncated = last && !complete;
        pending_writes.push_back(w);
        if (complete || w.truncated) finished = 1'b1;
      end else if (last) begin
        finished = 1'b1;
        w.write_offset = done_bytes;
        w.truncated = 1'b1;
        pending_writes.push_back(w);
      end
    endfunction

    function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        faults++;
      end
    endfunction

    function void match_write(input result_t got);
      result_t want;
      if (pending_writes.size() == 0) begin
        $error("write request with nothing expected, offset 0x%0h", got.write_offset);
        faults++;
        return;
      end
      want = pending_writes.pop_front();
      check_field("write_offset", want.write_offset, got.write_offset);
      check_field("pixel_value", want.pixel_value, got.pixel_value);
      check_field("repeat_count", want.repeat_count, got.repeat_count);
      check_field("byte_count", want.byte_count, got.byte_count);
      check_field("image_done", want.image_done, got.image_done);
      check_field("truncated", want.truncated, got.truncated);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [OffsetW-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         stream_byte_i;
  logic               stream_end_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [OffsetW-1:0] write_offset_o;
  logic [PixelW-1:0]  pixel_value_o;
  logic [RepW-1:0]    repeat_count_o;
  logic [CountW-1:0]  byte_count_o;
  logic               image_done_o;
  logic               truncated_o;

  rle_write_tracker board;
  bit tx_quiet;
  bit rx_hold;
  int total_sent;
  int ignored_sent;

  tga_rle_pixel_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .stream_end_i   (stream_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_offset_o (write_offset_o),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .byte_count_o   (byte_count_o),
    .image_done_o   (image_done_o),
    .truncated_o    (truncated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [7:0] pixel_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int n;
    if (!tx_quiet) begin
      n = gap_len();
      if (n > 0) begin
        in_valid_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    stream_end_i <= last;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.take_byte(b, last);
    total_sent++;
  endtask

  task automatic send_packet(input logic rep, input int pixels);
    int n;
    n = rep ? board.depth() : pixels * board.depth();
    send_byte({rep, 7'(pixels - 1)}, 1'b0);
    repeat (n) send_byte(pixel_byte(), 1'b0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [OffsetW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    board.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    int hold;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (rx_hold) begin
        hold = 300;
        rx_hold = 1'b0;
      end else begin
        hold = gap_len();
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1)
      board.match_write({write_offset_o, pixel_value_o, repeat_count_o, byte_count_o,
                         image_done_o, truncated_o});
  end

  initial begin
    logic [DepthW-1:0] bpp_plan [8];
    logic [DepthW-1:0] bpp_now;
    int ph, start, r, pixels;
    board = new();
    tx_quiet = 1'b0;
    rx_hold = 1'b0;
    total_sent = 0;
    ignored_sent = 0;
    bpp_plan = '{3'd1, 3'd2, 3'd4, 3'd0, 3'd5, 3'd3, 3'd7, 3'd6};
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= RegBytesPerPixel;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    stream_byte_i <= '0;
    stream_end_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // depth left at its reset value for the opening packets
    write_reg(RegImageBytes, ImgMax);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_packet(1'b1, 128);
    send_packet(1'b1, 1);
    send_packet(1'b0, 3);
    drain();

    // size at or below progress: bytes ignored, end flag included
    write_reg(RegImageBytes, '0);
    repeat (6) send_byte(pixel_byte(), 1'($urandom_range(1)));
    drain();
    write_reg(RegSpare2, 24'($urandom));
    write_reg(RegSpare3, 24'($urandom));
    write_reg(RegImageBytes, 24'($urandom_range(0, int'(board.done_bytes))));
    repeat (6) send_byte(pixel_byte(), 1'($urandom_range(1)));
    ignored_sent = 12;
    drain();
    write_reg(RegImageBytes, ImgMax);

    ph = 0;
    while (total_sent < ignored_sent + 1950) begin
      drain();
      bpp_now = (ph < 8) ? bpp_plan[ph] : 3'($urandom_range(7));
      write_reg(RegBytesPerPixel, {21'($urandom), bpp_now});
      if (ph % 2 == 1)
        write_reg(RegImageBytes, board.done_bytes + 24'($urandom_range(100000, 400000)));
      else
        write_reg(RegImageBytes, ImgMax);
      tx_quiet = (ph % 4 == 3);
      if (ph == 2) rx_hold = 1'b1;
      start = total_sent;
      while (total_sent - start < 180 && total_sent < ignored_sent + 1950) begin
        r = $urandom_range(99);
        if (r < 45) begin
          r = $urandom_range(9);
          pixels = (r == 0) ? 1 : (r == 1) ? 128 : $urandom_range(1, 128);
          send_packet(1'b1, pixels);
        end else if (r < 88) begin
          pixels = ($urandom_range(49) == 0) ? 128 : $urandom_range(1, 6);
          send_packet(1'b0, pixels);
        end else begin
          repeat ($urandom_range(1, 5)) send_byte(pixel_byte(), 1'b0);
        end
      end
      ph++;
    end

    // back to a packet boundary, then end by completion or by truncation
    tx_quiet = 1'b0;
    while (board.phase != WantHeader) send_byte(pixel_byte(), 1'b0);
    drain();
    if ($urandom_range(1) == 0) begin
      write_reg(RegImageBytes, board.done_bytes + 24'($urandom_range(1, 100)));
      while (!board.finished) send_packet(1'b1, 128);
    end else if ($urandom_range(1) == 0) begin
      send_byte(8'h03, 1'b1);
    end else begin
      send_byte(8'h03, 1'b0);
      repeat (3 * board.depth() - 1) send_byte(pixel_byte(), 1'b0);
      send_byte(pixel_byte(), 1'b1);
    end
    send_byte(pixel_byte(), 1'b0);
    send_byte(pixel_byte(), 1'b1);
    drain();

    if (board.faults == 0 && board.pending_writes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
